// ===== rtl/ir_pulse_distance_frame_encoder_core_defines.svh =====
// Assertion macros for the pulse-distance frame encoder.
// Included by the top level; no other dependencies.
`ifndef IR_PULSE_DISTANCE_FRAME_ENCODER_CORE_DEFINES_SVH
`define IR_PULSE_DISTANCE_FRAME_ENCODER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define IPDFE_ASSERT_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("ipdfe assertion failed");

// next-cycle implication, disabled during reset
`define IPDFE_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("ipdfe assertion failed");

`endif

// ===== rtl/ipdfe_pkg.sv =====
// Shared types and constants of the pulse-distance frame encoder.
// No dependencies.
`timescale 1ns / 1ps

package ipdfe_pkg;

   localparam int DUR_W             = 14;
   localparam int BYTE_W            = 8;
   localparam int CSR_INDEX_W       = 3;
   localparam int STEP_W            = 5;
   localparam int CMD_DEPTH_DEFAULT = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_LEADER_MARK  = 3'd0,
      REG_LEADER_SPACE = 3'd1,
      REG_BIT_MARK     = 3'd2,
      REG_ZERO_SPACE   = 3'd3,
      REG_ONE_SPACE    = 3'd4,
      REG_STOP_MARK    = 3'd5
   } reg_index_type;

   localparam logic [DUR_W-1:0] LEADER_MARK_RESET  = 14'd9000;
   localparam logic [DUR_W-1:0] LEADER_SPACE_RESET = 14'd4560;
   localparam logic [DUR_W-1:0] BIT_MARK_RESET     = 14'd500;
   localparam logic [DUR_W-1:0] ZERO_SPACE_RESET   = 14'd500;
   localparam logic [DUR_W-1:0] ONE_SPACE_RESET    = 14'd1800;
   localparam logic [DUR_W-1:0] STOP_MARK_RESET    = 14'd560;

   // segment sequence: leader mark, leader space, 16 data segments, stop mark
   localparam logic [STEP_W-1:0] STEP_LEADER_MARK  = 5'd0;
   localparam logic [STEP_W-1:0] STEP_LEADER_SPACE = 5'd1;
   localparam logic [STEP_W-1:0] STEP_FIRST_BIT    = 5'd2;
   localparam logic [STEP_W-1:0] STEP_LAST_BIT     = 5'd17;
   localparam logic [STEP_W-1:0] STEP_STOP_MARK    = 5'd18;

   typedef struct packed {
      logic [DUR_W-1:0] leader_mark_us;
      logic [DUR_W-1:0] leader_space_us;
      logic [DUR_W-1:0] bit_mark_us;
      logic [DUR_W-1:0] zero_space_us;
      logic [DUR_W-1:0] one_space_us;
      logic [DUR_W-1:0] stop_mark_us;
   } timing_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              leader;
      logic              stop;
   } cmd_type;

   typedef struct packed {
      logic              busy;
      logic [STEP_W-1:0] step;
   } back_status_type;

endpackage

// ===== rtl/ipdfe_front.sv =====
// Front end: accepts frame bytes, tracks the open frame and queues commands.
// Depends on ipdfe_pkg.
`timescale 1ns / 1ps

module ipdfe_front #(
   parameter int CMD_DEPTH = ipdfe_pkg::CMD_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [ipdfe_pkg::BYTE_W-1:0]      req_data_byte,
   input  logic                              req_end_of_frame,
   output logic                              cmd_valid,
   output ipdfe_pkg::cmd_type                cmd,
   input  logic                              cmd_pop
);
   import ipdfe_pkg::*;

   localparam int IDX_W = $clog2(CMD_DEPTH);
   localparam int CNT_W = $clog2(CMD_DEPTH + 1);

   cmd_type           queue_ff [CMD_DEPTH];
   logic [IDX_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              frame_open_ff, frame_open_in;
   logic              push_xfer;
   logic              pop_xfer;
   cmd_type           new_cmd;

   assign req_full  = (count_ff == CNT_W'(CMD_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign push_xfer = req_push && !req_full;
   assign pop_xfer  = cmd_pop && cmd_valid;

   always_comb begin
      new_cmd.data_byte = req_data_byte;
      new_cmd.leader    = !frame_open_ff;
      new_cmd.stop      = req_end_of_frame;

      frame_open_in = push_xfer ? !req_end_of_frame : frame_open_ff;

      wr_ptr_in = wr_ptr_ff;
      if (push_xfer) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (pop_xfer) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end

      count_in = count_ff;
      if (push_xfer && !pop_xfer) begin
         count_in = count_ff + 1'b1;
      end else if (pop_xfer && !push_xfer) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
         frame_open_ff <= 1'b0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
         frame_open_ff <= frame_open_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_xfer) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ===== rtl/ipdfe_back.sv =====
// Back end: steps through the segments of one queued byte into the result register,
// one per cycle while that register is empty or popped. Depends on ipdfe_pkg.
`timescale 1ns / 1ps

module ipdfe_back (
   input  logic                              clock,
   input  logic                              reset,
   input  ipdfe_pkg::timing_type             timing,
   input  logic                              cmd_valid,
   input  ipdfe_pkg::cmd_type                cmd,
   output logic                              cmd_pop,
   output ipdfe_pkg::back_status_type        status,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic                              rsp_drive_on,
   output logic [ipdfe_pkg::DUR_W-1:0]       rsp_duration_us,
   output logic                              rsp_run_last
);
   import ipdfe_pkg::*;

   logic                 busy_ff;
   logic [STEP_W-1:0]    step_ff;
   logic [BYTE_W-1:0]    byte_ff;
   logic                 stop_ff;
   logic                 rsp_valid_ff;
   logic                 drive_ff;
   logic [DUR_W-1:0]     dur_ff;
   logic                 last_ff;

   logic                 advance;
   logic                 load;
   logic                 seg_drive;
   logic [DUR_W-1:0]     seg_dur;
   logic                 seg_last;
   logic [STEP_W-1:0]    bit_offset;
   logic                 bit_value;

   assign advance = busy_ff && (!rsp_valid_ff || rsp_pop);
   assign load    = cmd_valid && (!busy_ff || (advance && seg_last));
   assign cmd_pop = load;

   assign status.busy = busy_ff;
   assign status.step = step_ff;

   assign rsp_empty       = !rsp_valid_ff;
   assign rsp_drive_on    = drive_ff;
   assign rsp_duration_us = dur_ff;
   assign rsp_run_last    = last_ff;

   always_comb begin
      bit_offset = step_ff - STEP_FIRST_BIT;
      bit_value  = byte_ff[bit_offset[$clog2(BYTE_W):1]];
      seg_last   = stop_ff ? (step_ff == STEP_STOP_MARK) : (step_ff == STEP_LAST_BIT);
      if (step_ff == STEP_LEADER_MARK) begin
         seg_drive = 1'b1;
         seg_dur   = timing.leader_mark_us;
      end else if (step_ff == STEP_LEADER_SPACE) begin
         seg_drive = 1'b0;
         seg_dur   = timing.leader_space_us;
      end else if (step_ff == STEP_STOP_MARK) begin
         seg_drive = 1'b1;
         seg_dur   = timing.stop_mark_us;
      end else if (!step_ff[0]) begin
         seg_drive = 1'b1;
         seg_dur   = timing.bit_mark_us;
      end else begin
         seg_drive = 1'b0;
         seg_dur   = bit_value ? timing.one_space_us : timing.zero_space_us;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= STEP_LEADER_MARK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            busy_ff <= 1'b1;
            step_ff <= cmd.leader ? STEP_LEADER_MARK : STEP_FIRST_BIT;
         end else if (advance) begin
            if (seg_last) begin
               busy_ff <= 1'b0;
            end else begin
               step_ff <= step_ff + 1'b1;
            end
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= cmd.data_byte;
         stop_ff <= cmd.stop;
      end
      if (advance) begin
         drive_ff <= seg_drive;
         dur_ff   <= seg_dur;
         last_ff  <= seg_last;
      end
   end

endmodule

// ===== rtl/ir_pulse_distance_frame_encoder_core.sv =====
// Top level of the pulse-distance frame encoder: timing registers,
// front end, back end. Depends on ipdfe_pkg, ipdfe_front, ipdfe_back.
//
// Usage:
//   Bytes enter as queue pushes (req_push / req_full) with the end-of-frame
//   flag. Each byte yields 16 segments, 2 more for the leader when it opens
//   a frame and 1 more for the stop mark when it ends one; the final segment
//   of a byte carries rsp_run_last. Segments leave as queue pops
//   (rsp_empty / rsp_pop).
//   When the back end is free, the first segment of a byte passes from the
//   command queue through the sequencer step register into the result register.
//   Segments leave one per cycle while rsp_pop stays high; the segment
//   sequencer in the back end sets this rate and loads the next queued byte
//   as it registers the last segment of the current one.
//   A command queue (CMD_DEPTH entries) takes new bytes while the back end
//   works; req_full rises when it fills.
//   When rsp_pop stays low the result register holds, the sequencer stops,
//   and the queue fills up until req_full backs up the sender.
//   Reset (synchronous) empties both sides, closes any open frame and loads
//   the timing registers with their default values.
//   csr_* writes take effect at once and are meant for idle periods.
`timescale 1ns / 1ps
`include "ir_pulse_distance_frame_encoder_core_defines.svh"

module ir_pulse_distance_frame_encoder_core #(
   parameter int CMD_DEPTH = ipdfe_pkg::CMD_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [ipdfe_pkg::BYTE_W-1:0]      req_data_byte,
   input  logic                              req_end_of_frame,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic                              rsp_drive_on,
   output logic [ipdfe_pkg::DUR_W-1:0]       rsp_duration_us,
   output logic                              rsp_run_last,
   input  logic                              csr_wr_en,
   input  logic [ipdfe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ipdfe_pkg::DUR_W-1:0]       csr_wdata
);
   import ipdfe_pkg::*;

   timing_type       timing_ff, timing_in;
   logic             cmd_valid;
   cmd_type          cmd;
   logic             cmd_pop;
   back_status_type  back_status;

   always_comb begin
      timing_in = timing_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_LEADER_MARK:  timing_in.leader_mark_us  = csr_wdata;
            REG_LEADER_SPACE: timing_in.leader_space_us = csr_wdata;
            REG_BIT_MARK:     timing_in.bit_mark_us     = csr_wdata;
            REG_ZERO_SPACE:   timing_in.zero_space_us   = csr_wdata;
            REG_ONE_SPACE:    timing_in.one_space_us    = csr_wdata;
            REG_STOP_MARK:    timing_in.stop_mark_us    = csr_wdata;
            default:          timing_in = timing_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.leader_mark_us  <= LEADER_MARK_RESET;
         timing_ff.leader_space_us <= LEADER_SPACE_RESET;
         timing_ff.bit_mark_us     <= BIT_MARK_RESET;
         timing_ff.zero_space_us   <= ZERO_SPACE_RESET;
         timing_ff.one_space_us    <= ONE_SPACE_RESET;
         timing_ff.stop_mark_us    <= STOP_MARK_RESET;
      end else begin
         timing_ff <= timing_in;
      end
   end

   ipdfe_front #(
      .CMD_DEPTH (CMD_DEPTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data_byte    (req_data_byte),
      .req_end_of_frame (req_end_of_frame),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop)
   );

   ipdfe_back u_back (
      .clock           (clock),
      .reset           (reset),
      .timing          (timing_ff),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop),
      .status          (back_status),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_drive_on    (rsp_drive_on),
      .rsp_duration_us (rsp_duration_us),
      .rsp_run_last    (rsp_run_last)
   );

   // a shown segment that is not the last of its byte means more are pending
   `IPDFE_ASSERT_SAME(a_pending_segments, clock, reset,
      !rsp_empty && !rsp_run_last, back_status.busy)

   // a transferred byte is queued or already taken by the sequencer
   `IPDFE_ASSERT_NEXT(a_push_lands, clock, reset,
      req_push && !req_full, cmd_valid || back_status.busy)

   // the sequencer never runs past the stop mark
   `IPDFE_ASSERT_SAME(a_step_range, clock, reset,
      back_status.busy, back_status.step <= STEP_STOP_MARK)

endmodule

// ===== tb/sv/ir_pulse_distance_frame_encoder_core_tb.sv =====
// Self-checking testbench for ir_pulse_distance_frame_encoder_core: a directed table, then
// random frames under several timing settings, each segment checked against a local encoder
// or a literal list. Depends on ipdfe_pkg and the core RTL.
`timescale 1ns / 1ps

module ir_pulse_distance_frame_encoder_core_tb;
   import ipdfe_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_7 = 3'd7;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASES       = 7;
   localparam int PHASE_BYTES  = 14;
   localparam int NUM_ROWS     = 32;

   localparam logic [DUR_W-1:0] REG_DEFAULTS [6] = '{LEADER_MARK_RESET, LEADER_SPACE_RESET,
      BIT_MARK_RESET, ZERO_SPACE_RESET, ONE_SPACE_RESET, STOP_MARK_RESET};

   // full runs at reset timing for bytes 0x00 and 0xFF
   localparam logic [0:18][DUR_W-1:0] DURS_ZERO_BYTE = '{14'd9000, 14'd4560,
      14'd500, 14'd500, 14'd500, 14'd500, 14'd500, 14'd500, 14'd500, 14'd500,
      14'd500, 14'd500, 14'd500, 14'd500, 14'd500, 14'd500, 14'd500, 14'd500, 14'd560};
   localparam logic [0:18][DUR_W-1:0] DURS_ONES_BYTE = '{14'd9000, 14'd4560,
      14'd500, 14'd1800, 14'd500, 14'd1800, 14'd500, 14'd1800, 14'd500, 14'd1800,
      14'd500, 14'd1800, 14'd500, 14'd1800, 14'd500, 14'd1800, 14'd500, 14'd1800, 14'd560};
   localparam logic [0:18][DUR_W-1:0] DURS_ALL_MAX = '{default: 14'h3FFF};

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type             kind;
      logic [CSR_INDEX_W-1:0]   idx;
      logic [DUR_W-1:0]         wdata;
      logic [BYTE_W-1:0]        data;
      logic                     eof;
      logic [4:0]               lit_n;
      logic [0:18][DUR_W-1:0]   lit_dur;
   } stim_row_type;

   typedef struct packed {
      logic             drive_on;
      logic [DUR_W-1:0] duration_us;
      logic             run_last;
   } segment_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_push;
   logic                   req_full;
   logic [BYTE_W-1:0]      req_data_byte;
   logic                   req_end_of_frame;
   logic                   rsp_empty;
   logic                   rsp_pop;
   logic                   rsp_drive_on;
   logic [DUR_W-1:0]       rsp_duration_us;
   logic                   rsp_run_last;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [DUR_W-1:0]       csr_wdata;

   timing_type   timing_now;
   bit           frame_open_now;
   segment_type  segments_due[$];
   segment_type  byte_segments[$];
   segment_type  want;
   stim_row_type directed_rows [0:NUM_ROWS-1];
   int           errors;
   int           cycles;
   int           stall_left;
   bit           gaps_on;

   ir_pulse_distance_frame_encoder_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data_byte    (req_data_byte),
      .req_end_of_frame (req_end_of_frame),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_drive_on     (rsp_drive_on),
      .rsp_duration_us  (rsp_duration_us),
      .rsp_run_last     (rsp_run_last),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic void add_segment(logic level, logic [DUR_W-1:0] dur);
      byte_segments.push_back('{level, dur, 1'b0});
   endfunction

   function automatic void encode_byte(logic [BYTE_W-1:0] data, logic eof);
      segment_type tail;
      byte_segments.delete();
      if (!frame_open_now) begin
         add_segment(1'b1, timing_now.leader_mark_us);
         add_segment(1'b0, timing_now.leader_space_us);
         frame_open_now = 1'b1;
      end
      for (int b = 0; b < BYTE_W; b++) begin
         add_segment(1'b1, timing_now.bit_mark_us);
         add_segment(1'b0, data[b] ? timing_now.one_space_us : timing_now.zero_space_us);
      end
      if (eof) begin
         add_segment(1'b1, timing_now.stop_mark_us);
         frame_open_now = 1'b0;
      end
      tail = byte_segments.pop_back();
      tail.run_last = 1'b1;
      byte_segments.push_back(tail);
   endfunction

   function automatic void set_register(logic [CSR_INDEX_W-1:0] idx, logic [DUR_W-1:0] value);
      case (idx)
         REG_LEADER_MARK:  timing_now.leader_mark_us  = value;
         REG_LEADER_SPACE: timing_now.leader_space_us = value;
         REG_BIT_MARK:     timing_now.bit_mark_us     = value;
         REG_ZERO_SPACE:   timing_now.zero_space_us   = value;
         REG_ONE_SPACE:    timing_now.one_space_us    = value;
         REG_STOP_MARK:    timing_now.stop_mark_us    = value;
         default: ;
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 9);
      if (!gaps_on || r < 5) return 0;
      if (r < 9) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic sender_idle(int n);
      if (n > 0) begin
         @(negedge clock);
         req_push <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // literal expectations replace the local encoder's output when lit_n is nonzero
   task automatic send_byte(logic [BYTE_W-1:0] data, logic eof, logic [4:0] lit_n,
                            logic [0:18][DUR_W-1:0] lit_dur);
      @(negedge clock);
      req_push         <= 1'b1;
      req_data_byte    <= data;
      req_end_of_frame <= eof;
      do @(posedge clock); while (req_full);
      encode_byte(data, eof);
      if (lit_n == 0) begin
         foreach (byte_segments[k]) segments_due.push_back(byte_segments[k]);
      end else begin
         for (int k = 0; k < lit_n; k++)
            segments_due.push_back('{(k % 2) == 0, lit_dur[k], k == lit_n - 1});
      end
   endtask

   task automatic drain_results();
      sender_idle(1);
      while (segments_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, logic [DUR_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      set_register(idx, value);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
         stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (segments_due.size() == 0) begin
            $display("%0t: segment with none expected: drive_on %0b duration_us %0d run_last %0b",
                     $time, rsp_drive_on, rsp_duration_us, rsp_run_last);
            errors++;
         end else begin
            want = segments_due.pop_front();
            if (rsp_drive_on !== want.drive_on) begin
               $display("%0t: drive_on expected %0b actual %0b",
                        $time, want.drive_on, rsp_drive_on);
               errors++;
            end
            if (rsp_duration_us !== want.duration_us) begin
               $display("%0t: duration_us expected %0d actual %0d",
                        $time, want.duration_us, rsp_duration_us);
               errors++;
            end
            if (rsp_run_last !== want.run_last) begin
               $display("%0t: run_last expected %0b actual %0b",
                        $time, want.run_last, rsp_run_last);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("ir_pulse_distance_frame_encoder_core test failed");
         $finish;
      end
   end

   initial begin
      int               sent;
      int               frame_left;
      logic             eof;
      logic [DUR_W-1:0] value;

      reset            = 1'b1;
      req_push         = 1'b0;
      req_data_byte    = '0;
      req_end_of_frame = 1'b0;
      rsp_pop          = 1'b0;
      csr_wr_en        = 1'b0;
      csr_index        = REG_LEADER_MARK;
      csr_wdata        = '0;
      errors           = 0;
      cycles           = 0;
      stall_left       = 0;
      gaps_on          = 1'b1;
      frame_open_now   = 1'b0;
      for (int r = REG_LEADER_MARK; r <= REG_STOP_MARK; r++)
         set_register(CSR_INDEX_W'(r), REG_DEFAULTS[r]);

      directed_rows = '{
         '{ROW_ITEM, '0, '0, 8'h00, 1'b1, 5'd19, DURS_ZERO_BYTE},
         '{ROW_ITEM, '0, '0, 8'hFF, 1'b1, 5'd19, DURS_ONES_BYTE},
         '{ROW_ITEM, '0, '0, 8'h01, 1'b0, 5'd0, '0},
         '{ROW_ITEM, '0, '0, 8'h80, 1'b0, 5'd0, '0},
         '{ROW_ITEM, '0, '0, 8'h55, 1'b0, 5'd0, '0},
         '{ROW_ITEM, '0, '0, 8'hAA, 1'b1, 5'd0, '0},
         '{ROW_CSR, REG_LEADER_MARK,  14'd0, '0, 1'b0, 5'd0, '0},
         '{ROW_CSR, REG_LEADER_SPACE, 14'd0, '0, 1'b0, 5'd0, '0},
         '{ROW_CSR, REG_BIT_MARK,     14'd0, '0, 1'b0, 5'd0, '0},
         '{ROW_CSR, REG_ZERO_SPACE,   14'd0, '0, 1'b0, 5'd0, '0},
         '{ROW_CSR, REG_ONE_SPACE,    14'd0, '0, 1'b0, 5'd0, '0},
         '{ROW_CSR, REG_STOP_MARK,    14'd0, '0, 1'b0, 5'd0, '0},
         '{ROW_ITEM, '0, '0, 8'h3C, 1'b1, 5'd19, '0},
         '{ROW_CSR, REG_LEADER_MARK,  14'h3FFF, '0, 1'b0, 5'd0, '0},
         '{ROW_CSR, REG_LEADER_SPACE, 14'h3FFF, '0, 1'b0, 5'd0, '0},
         '{ROW_CSR, REG_BIT_MARK,     14'h3FFF, '0, 1'b0, 5'd0, '0},
         '{ROW_CSR, REG_ZERO_SPACE,   14'h3FFF, '0, 1'b0, 5'd0, '0},
         '{ROW_CSR, REG_ONE_SPACE,    14'h3FFF, '0, 1'b0, 5'd0, '0},
         '{ROW_CSR, REG_STOP_MARK,    14'h3FFF, '0, 1'b0, 5'd0, '0},
         '{ROW_ITEM, '0, '0, 8'hA5, 1'b0, 5'd18, DURS_ALL_MAX},
         '{ROW_ITEM, '0, '0, 8'h5A, 1'b1, 5'd17, DURS_ALL_MAX},
         '{ROW_CSR, REG_LEADER_MARK,  14'h2AAA, '0, 1'b0, 5'd0, '0},
         '{ROW_CSR, REG_LEADER_SPACE, 14'h1555, '0, 1'b0, 5'd0, '0},
         '{ROW_CSR, REG_BIT_MARK,     14'd1,    '0, 1'b0, 5'd0, '0},
         '{ROW_CSR, REG_ZERO_SPACE,   14'd2,    '0, 1'b0, 5'd0, '0},
         '{ROW_CSR, REG_ONE_SPACE,    14'd3,    '0, 1'b0, 5'd0, '0},
         '{ROW_CSR, REG_STOP_MARK,    14'h2000, '0, 1'b0, 5'd0, '0},
         '{ROW_CSR, REG_SPARE_6,      14'h3FFF, '0, 1'b0, 5'd0, '0},
         '{ROW_CSR, REG_SPARE_7,      14'd0,    '0, 1'b0, 5'd0, '0},
         '{ROW_ITEM, '0, '0, 8'hC3, 1'b0, 5'd0, '0},
         '{ROW_ITEM, '0, '0, 8'h0F, 1'b1, 5'd0, '0},
         '{ROW_ITEM, '0, '0, 8'hE7, 1'b1, 5'd0, '0}
      };

      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            drain_results();
            write_register(directed_rows[i].idx, directed_rows[i].wdata);
         end else begin
            send_byte(directed_rows[i].data, directed_rows[i].eof, directed_rows[i].lit_n,
                      directed_rows[i].lit_dur);
            sender_idle(pick_gap());
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results();
         gaps_on = (phase != 4);
         for (int r = REG_LEADER_MARK; r <= REG_STOP_MARK; r++) begin
            case (phase % 4)
               0:       value = REG_DEFAULTS[r];
               1:       value = 14'h3FFF;
               2:       value = 14'd0;
               default: value = DUR_W'($urandom_range(0, 16383));
            endcase
            write_register(CSR_INDEX_W'(r), value);
         end
         if ($urandom_range(0, 1))
            write_register($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7,
                           DUR_W'($urandom_range(0, 16383)));
         sent = 0;
         while (sent < PHASE_BYTES) begin
            frame_left = $urandom_range(1, 4);
            if (frame_left > PHASE_BYTES - sent) frame_left = PHASE_BYTES - sent;
            while (frame_left > 0) begin
               eof = (frame_left == 1);
               if ($urandom_range(0, 9) == 0) eof = 1'($urandom_range(0, 1));
               send_byte(BYTE_W'($urandom_range(0, 255)), eof, 5'd0, '0);
               sent++;
               frame_left--;
               if ($urandom_range(0, 24) == 0) drain_results();
               else sender_idle(pick_gap());
            end
         end
      end

      drain_results();
      if (errors == 0) begin
         $display("ir_pulse_distance_frame_encoder_core test passed");
      end else begin
         $display("ir_pulse_distance_frame_encoder_core test failed");
      end
      $finish;
   end

endmodule
